[hw/rtl/spca_pkg.sv]
// Shared types and constants for the server pool countdown allocator.
// No dependencies; used by spca_ctrl, spca_dp and the top level.
package spca_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int IDX_W       = $clog2(MAX_SERVERS);
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int DATA_W      = 16;
  localparam int TIME_W      = 18;
  localparam int CFG_W       = 5;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_ASSIGN = 1'b1;

  typedef struct packed {
    logic load;      // item accepted this cycle
    logic scan;      // walk one active server
    logic clr_ptr;   // rewind pointer for departure walk
    logic emit_dep;  // walk pending departures, load result when possible
    logic emit_one;  // load the single assign / empty-tick result
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_tick;
    logic any_dep;
    logic last_pend;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/spca_ctrl.sv]
// Controller for the server pool allocator: sequences accept, scan and result walk.
// Depends on spca_pkg.
module spca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spca_pkg::sts_t     sts,
  output spca_pkg::cmd_t     cmd
);
  import spca_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_ONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.is_tick && sts.any_dep) begin
            cmd.clr_ptr = 1'b1;
            state_nxt   = S_EMIT;
          end else begin
            state_nxt = S_ONE;
          end
        end
      end
      S_EMIT: begin
        cmd.emit_dep = 1'b1;
        if (sts.last_pend) begin
          state_nxt = S_IDLE;
        end
      end
      S_ONE: begin
        cmd.emit_one = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/spca_dp.sv]
// Datapath for the server pool allocator: server tables, scan pointer,
// status accumulators, config register and the output register. Depends on spca_pkg.
module spca_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spca_pkg::cmd_t                   cmd,
  output spca_pkg::sts_t                   sts,
  input  logic                             cfg_we,
  input  logic [spca_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_mode,
  input  logic [spca_pkg::IDX_W-1:0]       in_server_index,
  input  logic [spca_pkg::DATA_W-1:0]      in_customer_number,
  input  logic [spca_pkg::DATA_W-1:0]      in_arrival_time,
  input  logic [spca_pkg::DATA_W-1:0]      in_waiting_time,
  input  logic [spca_pkg::DATA_W-1:0]      in_service_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_departed,
  output logic [spca_pkg::IDX_W-1:0]       out_depart_server,
  output logic [spca_pkg::DATA_W-1:0]      out_depart_customer,
  output logic [spca_pkg::TIME_W-1:0]      out_depart_time,
  output logic                             out_last_result,
  output logic                             out_free_available,
  output logic [spca_pkg::IDX_W-1:0]       out_first_free,
  output logic [spca_pkg::CNT_W-1:0]       out_busy_count,
  output logic                             out_bad_request
);
  import spca_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SERVERS);

  logic [CFG_W-1:0]       sui_r;
  logic [MAX_SERVERS-1:0] busy_r;
  logic [DATA_W-1:0]      rem_r  [MAX_SERVERS];
  logic [DATA_W-1:0]      cust_r [MAX_SERVERS];
  logic [TIME_W-1:0]      fin_r  [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] pend_r;
  logic [CNT_W-1:0]       dep_cnt_r;
  logic [CNT_W-1:0]       ptr_r;
  logic [CNT_W-1:0]       busy_cnt_r;
  logic                   found_r;
  logic [IDX_W-1:0]       first_r;
  logic                   mode_r;
  logic                   bad_r;
  logic                   out_valid_r;
  logic                   out_dep_r;
  logic [IDX_W-1:0]       out_srv_r;
  logic [DATA_W-1:0]      out_cust_r;
  logic [TIME_W-1:0]      out_time_r;
  logic                   out_last_r;
  logic                   out_free_r;
  logic [IDX_W-1:0]       out_first_r;
  logic [CNT_W-1:0]       out_busy_r;
  logic                   out_bad_r;

  logic [CNT_W-1:0]       act;
  logic [IDX_W-1:0]       pidx;
  logic [DATA_W-1:0]      dec;
  logic                   hit_zero;
  logic                   now_busy;
  logic                   scan_step;
  logic                   in_bad;
  logic [DATA_W-1:0]      svc;
  logic [TIME_W-1:0]      fin_sum;
  logic                   out_free;
  logic                   pend_hit;
  logic                   load_dep;
  logic                   load_one;

  assign act       = (sui_r > MAX_CNT) ? MAX_CNT : sui_r;
  assign pidx      = ptr_r[IDX_W-1:0];
  assign dec       = rem_r[pidx] - DATA_W'(1);
  assign hit_zero  = (mode_r == MODE_TICK) && busy_r[pidx] && (dec == '0);
  assign now_busy  = busy_r[pidx] && !hit_zero;
  assign scan_step = cmd.scan && !cmd.clr_ptr && (ptr_r < act);
  assign in_bad    = (in_mode == MODE_ASSIGN) && ({1'b0, in_server_index} >= act);
  assign svc       = (in_service_time == '0) ? DATA_W'(1) : in_service_time;
  assign fin_sum   = TIME_W'(in_arrival_time) + TIME_W'(in_waiting_time) + TIME_W'(svc);
  assign out_free  = !out_valid_r || !out_stall;
  assign pend_hit  = pend_r[pidx];
  assign load_dep  = cmd.emit_dep && pend_hit && out_free;
  assign load_one  = cmd.emit_one && out_free;

  assign sts.scan_done = (ptr_r >= act);
  assign sts.is_tick   = (mode_r == MODE_TICK);
  assign sts.any_dep   = (dep_cnt_r != '0);
  assign sts.last_pend = load_dep && (dep_cnt_r == CNT_W'(1));
  assign sts.out_free  = out_free;

  // config register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sui_r       <= CFG_W'(1);
      busy_r      <= '0;
      pend_r      <= '0;
      dep_cnt_r   <= '0;
      ptr_r       <= '0;
      busy_cnt_r  <= '0;
      found_r     <= 1'b0;
      first_r     <= '0;
      mode_r      <= MODE_TICK;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sui_r <= cfg_wdata;
      end
      if (cmd.load) begin
        mode_r     <= in_mode;
        bad_r      <= in_bad;
        pend_r     <= '0;
        dep_cnt_r  <= '0;
        ptr_r      <= '0;
        busy_cnt_r <= '0;
        found_r    <= 1'b0;
        first_r    <= '0;
        if ((in_mode == MODE_ASSIGN) && !in_bad) begin
          busy_r[in_server_index] <= 1'b1;
        end
      end else if (cmd.clr_ptr) begin
        ptr_r <= '0;
      end else if (scan_step) begin
        ptr_r      <= ptr_r + CNT_W'(1);
        busy_cnt_r <= busy_cnt_r + CNT_W'(now_busy);
        if (hit_zero) begin
          busy_r[pidx] <= 1'b0;
          pend_r[pidx] <= 1'b1;
          dep_cnt_r    <= dep_cnt_r + CNT_W'(1);
        end
        if (!now_busy && !found_r) begin
          found_r <= 1'b1;
          first_r <= pidx;
        end
      end else if (cmd.emit_dep) begin
        if (load_dep) begin
          pend_r[pidx] <= 1'b0;
          dep_cnt_r    <= dep_cnt_r - CNT_W'(1);
          ptr_r        <= ptr_r + CNT_W'(1);
        end else if (!pend_hit) begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
      end
      if (load_dep || load_one) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // server tables
  always_ff @(posedge clk) begin
    if (cmd.load && (in_mode == MODE_ASSIGN) && !in_bad) begin
      rem_r[in_server_index]  <= svc;
      cust_r[in_server_index] <= in_customer_number;
      fin_r[in_server_index]  <= fin_sum;
    end else if (scan_step && (mode_r == MODE_TICK) && busy_r[pidx]) begin
      rem_r[pidx] <= dec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_dep || load_one) begin
      out_dep_r   <= load_dep;
      out_srv_r   <= load_dep ? pidx : '0;
      out_cust_r  <= load_dep ? cust_r[pidx] : '0;
      out_time_r  <= load_dep ? fin_r[pidx] : '0;
      out_last_r  <= load_one || (dep_cnt_r == CNT_W'(1));
      out_bad_r   <= load_one && bad_r;
      out_free_r  <= found_r;
      out_first_r <= first_r;
      out_busy_r  <= busy_cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_departed        = out_dep_r;
  assign out_depart_server   = out_srv_r;
  assign out_depart_customer = out_cust_r;
  assign out_depart_time     = out_time_r;
  assign out_last_result     = out_last_r;
  assign out_free_available  = out_free_r;
  assign out_first_free      = out_first_r;
  assign out_busy_count      = out_busy_r;
  assign out_bad_request     = out_bad_r;

`ifndef SYNTHESIS
  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pend_r) == dep_cnt_r)
    else $error("pending departures and departure count disagree");

  a_pend_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & busy_r) == '0)
    else $error("server pending departure is still busy");

  a_bad_only_assign: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |-> (mode_r == MODE_ASSIGN))
    else $error("bad request flagged on a tick");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_dep && cmd.emit_one))
    else $error("two result loads in one cycle");
`endif

endmodule

[hw/rtl/server_pool_countdown_allocator_unit.sv]
// Server pool countdown allocator: an assign item loads one server; a tick item
// counts down every busy active server and reports each one that frees up.
// Depends on spca_pkg, spca_ctrl and spca_dp.
//
// The single scan pointer sets the pace: one server is counted down and tallied
// per cycle, then the pointer walks the server indices again up to the highest
// departing one, holding on each pending departure while the result side stalls.
// One item is in work at a time; results leave through an output register, and
// every result carries the lowest free server and busy count after the whole item.
// servers_in_use above 16 acts as 16; 0 makes every assign bad and every tick empty.
module server_pool_countdown_allocator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spca_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [spca_pkg::IDX_W-1:0]       in_server_index,
  input  logic [spca_pkg::DATA_W-1:0]      in_customer_number,
  input  logic [spca_pkg::DATA_W-1:0]      in_arrival_time,
  input  logic [spca_pkg::DATA_W-1:0]      in_waiting_time,
  input  logic [spca_pkg::DATA_W-1:0]      in_service_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_departed,
  output logic [spca_pkg::IDX_W-1:0]       out_depart_server,
  output logic [spca_pkg::DATA_W-1:0]      out_depart_customer,
  output logic [spca_pkg::TIME_W-1:0]      out_depart_time,
  output logic                             out_last_result,
  output logic                             out_free_available,
  output logic [spca_pkg::IDX_W-1:0]       out_first_free,
  output logic [spca_pkg::CNT_W-1:0]       out_busy_count,
  output logic                             out_bad_request
);
  import spca_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_stall = !in_ready;

  spca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spca_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_mode),
    .in_server_index     (in_server_index),
    .in_customer_number  (in_customer_number),
    .in_arrival_time     (in_arrival_time),
    .in_waiting_time     (in_waiting_time),
    .in_service_time     (in_service_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_departed        (out_departed),
    .out_depart_server   (out_depart_server),
    .out_depart_customer (out_depart_customer),
    .out_depart_time     (out_depart_time),
    .out_last_result     (out_last_result),
    .out_free_available  (out_free_available),
    .out_first_free      (out_first_free),
    .out_busy_count      (out_busy_count),
    .out_bad_request     (out_bad_request)
  );

endmodule
